@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the decoder core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define AST_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check that a condition is followed by a property in the next cycle.
`define AST_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

@@ rtl/core/afd_pkg.sv @@
// Shared types and constants of the ADPCM frame decoder core.
package afd_pkg;

	localparam int NP_DEFAULT   = 16;
	localparam int FRAME_BYTES  = 9;
	localparam int SHIFT_BASE   = 9;
	localparam int OUT_SHIFT    = 10;
	localparam int ACC_W        = 34;
	localparam int IN_TDATA_W   = 32;
	localparam int IN_TUSER_W   = 2;
	localparam int OUT_TDATA_W  = 16;
	localparam logic signed [15:0] SAT_MAX = 16'sd32767;
	localparam logic signed [15:0] SAT_MIN = -16'sd32767;

	// Request kinds carried on the input tuser
	typedef enum logic [1:0] {
		REQ_COEF  = 2'd0,
		REQ_HIST  = 2'd1,
		REQ_BYTE  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic rd0;
		logic rd1;
		logic mul1;
		logic sum;
		logic sat;
		logic nib_sel;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic data_byte;
		logic out_free;
	} stat_t;

endpackage

@@ rtl/core/afd_ctrl.sv @@
// Sequencer that steps the datapath through the two samples of a data byte.
`include "assert_macros.svh"

module afd_ctrl
	import afd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_MUL1,
		ST_SUM,
		ST_SAT
	} state_t;

	state_t state_q;
	logic   nib_q;

	// Decode commands from the current state
	always_comb begin
		cmd         = '0;
		cmd.nib_sel = nib_q;
		s_tready    = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: cmd.accept = s_tvalid;
			ST_RD0:  cmd.rd0    = 1'b1;
			ST_RD1:  cmd.rd1    = 1'b1;
			ST_MUL1: cmd.mul1   = 1'b1;
			ST_SUM:  cmd.sum    = 1'b1;
			ST_SAT:  cmd.sat    = stat.out_free;
			default: cmd        = '0;
		endcase
	end

	// Advance the sequence; hold in the saturate step while the output is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nib_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && stat.data_byte) begin
						state_q <= ST_RD0;
						nib_q   <= 1'b0;
					end
				end
				ST_RD0:  state_q <= ST_RD1;
				ST_RD1:  state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_SAT;
				ST_SAT: begin
					if (stat.out_free) begin
						if (!nib_q) begin
							nib_q   <= 1'b1;
							state_q <= ST_RD0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`AST_CHECK(a_cmd_onehot, $onehot0({cmd.accept, cmd.rd0, cmd.rd1, cmd.mul1, cmd.sum, cmd.sat}), "more than one datapath command at once")
	`AST_CHECK(a_rd0_origin, cmd.rd0 |-> ($past(cmd.accept) || $past(cmd.sat)), "sample read started without a byte or a finished first sample")

endmodule

@@ rtl/core/afd_dpath.sv @@
// Datapath: coefficient memory, history, frame position, MAC and output register.
`include "assert_macros.svh"

module afd_dpath
	import afd_pkg::*;
#(
	parameter int NUM_PREDICTORS = NP_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic [IN_TUSER_W-1:0]  s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tuser,
	output logic                   m_tlast
);

	localparam int DEPTH = 2 * NUM_PREDICTORS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [5:0] DEPTH_L = 6'(DEPTH);
	localparam logic [4:0] NP_L    = 5'(NUM_PREDICTORS);

	// Unpack the input word
	logic        [4:0]  slot;
	logic signed [15:0] wval;
	logic        [7:0]  fbyte;
	req_t               req;

	assign slot  = s_tdata[4:0];
	assign wval  = s_tdata[20:5];
	assign fbyte = s_tdata[28:21];
	assign req   = req_t'(s_tuser);

	// Stored state
	logic signed [15:0] coef_mem [DEPTH];
	logic [DEPTH-1:0]   coef_vld_q;
	logic signed [15:0] hist_older_q;
	logic signed [15:0] hist_newer_q;
	logic [3:0]         pos_q;
	logic [4:0]         shift_q;
	logic [3:0]         pred_q;
	logic [7:0]         byte_q;
	logic               last_q;

	// Working registers
	logic signed [15:0]      rdata_q;
	logic                    rd_ok_q;
	logic signed [31:0]      prod_q;
	logic signed [ACC_W-1:0] acc_q;

	// Output register
	logic                    out_vld_q;
	logic signed [15:0]      sample_q;
	logic                    pair_q;
	logic                    fend_q;

	logic              slot_ok;
	logic              pred_ok;
	logic [4:0]        rd_slot;
	logic [AW-1:0]     rd_addr;
	logic              is_header;
	logic              is_data;
	logic              byte_last;
	logic signed [15:0] coef_eff;
	logic signed [15:0] mul_a;
	logic signed [31:0] mul_p;
	logic        [3:0]  nib;
	logic signed [ACC_W-1:0] nib_term;
	logic signed [ACC_W-1:0] acc_sh;
	logic signed [15:0] sat_val;

	assign slot_ok   = ({1'b0, slot} < DEPTH_L);
	assign pred_ok   = ({1'b0, pred_q} < NP_L);
	assign rd_slot   = {pred_q, cmd.rd1};
	assign rd_addr   = rd_slot[AW-1:0];
	assign is_header = (req == REQ_BYTE) && (pos_q == 4'd0);
	assign is_data   = (req == REQ_BYTE) && (pos_q != 4'd0);
	assign byte_last = (pos_q >= 4'(FRAME_BYTES - 1));

	assign stat.data_byte = is_data;
	assign stat.out_free  = !out_vld_q || m_tready;

	// Tap coefficient: arithmetic shift right by two, then doubled
	assign coef_eff = rd_ok_q ? {rdata_q[15], rdata_q[15:2], 1'b0} : 16'sd0;
	assign mul_a    = cmd.rd1 ? hist_older_q : hist_newer_q;
	assign mul_p    = 32'(mul_a) * 32'(coef_eff);

	// Scaled residual of the current nibble
	assign nib      = cmd.nib_sel ? byte_q[3:0] : byte_q[7:4];
	assign nib_term = ACC_W'(signed'(nib)) <<< shift_q;

	// Scale down and saturate
	assign acc_sh = acc_q >>> OUT_SHIFT;
	always_comb begin
		if (acc_sh > ACC_W'(SAT_MAX)) begin
			sat_val = SAT_MAX;
		end else if (acc_sh < ACC_W'(SAT_MIN)) begin
			sat_val = SAT_MIN;
		end else begin
			sat_val = acc_sh[15:0];
		end
	end

	// Coefficient memory: write on request, read one tap per step
	always_ff @(posedge clk) begin
		if (cmd.accept && req == REQ_COEF && slot_ok) begin
			coef_mem[slot[AW-1:0]] <= wval;
		end
		if (cmd.rd0 || cmd.rd1) begin
			rdata_q <= coef_mem[rd_addr];
			rd_ok_q <= pred_ok && coef_vld_q[rd_addr];
		end
	end

	// Mark written slots; unwritten slots read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
		end else if (cmd.accept && req == REQ_COEF && slot_ok) begin
			coef_vld_q[slot[AW-1:0]] <= 1'b1;
		end
	end

	// Frame position, header fields and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_older_q <= '0;
			hist_newer_q <= '0;
			pos_q        <= '0;
			shift_q      <= '0;
			pred_q       <= '0;
		end else if (cmd.accept) begin
			case (req)
				REQ_HIST: begin
					if (slot == 5'd0) begin
						hist_older_q <= wval;
					end else if (slot == 5'd1) begin
						hist_newer_q <= wval;
					end
				end
				REQ_CLEAR: begin
					hist_older_q <= '0;
					hist_newer_q <= '0;
					pos_q        <= '0;
				end
				REQ_BYTE: begin
					if (is_header) begin
						shift_q <= {1'b0, fbyte[7:4]} + 5'(SHIFT_BASE);
						pred_q  <= fbyte[3:0];
						pos_q   <= 4'd1;
					end else begin
						pos_q <= byte_last ? 4'd0 : pos_q + 4'd1;
					end
				end
				default: ;
			endcase
		end else if (cmd.sat) begin
			hist_older_q <= hist_newer_q;
			hist_newer_q <= sat_val;
		end
	end

	// Data byte and multiply-accumulate
	always_ff @(posedge clk) begin
		if (cmd.accept && is_data) begin
			byte_q <= fbyte;
			last_q <= byte_last;
		end
		if (cmd.rd1 || cmd.mul1) begin
			prod_q <= mul_p;
		end
		if (cmd.rd1) begin
			acc_q <= nib_term;
		end else if (cmd.mul1 || cmd.sum) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
	end

	// Output register: load a sample, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.sat) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sat) begin
			sample_q <= sat_val;
			pair_q   <= cmd.nib_sel;
			fend_q   <= cmd.nib_sel && last_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = sample_q;
	assign m_tuser  = pair_q;
	assign m_tlast  = fend_q;

	`AST_CHECK(a_no_overwrite, cmd.sat |-> (!out_vld_q || m_tready), "sample loaded over an untaken word")
	`AST_NEXT(a_hist_follows, cmd.sat, (out_vld_q && hist_newer_q == sample_q), "history does not track the sample sent")
	`AST_CHECK(a_pos_range, pos_q < 4'(FRAME_BYTES), "frame position out of range")

endmodule

@@ rtl/core/adpcm_frame_decoder_core.sv @@
// ADPCM frame decoder: usage
//
// Input stream (s_*): one word per item. s_tuser is the request kind (write
// coefficient, set history, frame byte, clear history). A frame is a header
// byte followed by eight data bytes; each data byte yields two samples.
// Output stream (m_*): one 16-bit sample per word, m_tuser marks the second
// sample of a byte, m_tlast the sixteenth sample of a frame.
// Sequencing: writes, clears and headers are taken in the idle state. A data
// byte is accepted, then each of its two samples steps through two coefficient
// reads from the single-port table, two products through one 16x16 multiplier,
// a sum and a saturate; the saturate step loads each sample into the output
// register on m_*.
// Reset clears history, frame position, header fields and marks every
// coefficient slot as zero. When the receiver stalls, the held sample stays
// on m_* and the sequencer waits in its saturate step; a new input word is
// taken once the second sample of the previous byte is in the output register.
module adpcm_frame_decoder_core
	import afd_pkg::*;
#(
	parameter int NUM_PREDICTORS = NP_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // slot_index[4:0], write_value[20:5], frame_byte[28:21], zero
	input  logic [IN_TUSER_W-1:0]  s_tuser,  // req_type[1:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // sample[15:0]
	output logic                   m_tuser,  // pair_last[0]
	output logic                   m_tlast   // frame_end
);

	cmd_t  cmd;
	stat_t stat;

	// Sequencer
	afd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath
	afd_dpath #(
		.NUM_PREDICTORS (NUM_PREDICTORS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the ADPCM frame decoder core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import afd_pkg::*;

	localparam int NUM_PRED   = NP_DEFAULT;
	localparam int SOAK_WORDS = 2000;
	localparam int DRAIN_WAIT = 30;

	// One decoded sample as it leaves the block
	typedef struct packed {
		logic signed [15:0] sample;
		logic               pair_last;
		logic               frame_end;
	} pcm_word_t;

	// Receiver stall patterns
	typedef enum int {
		RX_FREE,
		RX_RANDOM,
		RX_SLOW,
		RX_HOLD
	} rx_mode_t;

	// Decoder model plus the queue of samples it still owes
	class pcm_scoreboard;
		logic signed [15:0] coef_mem [32];
		logic signed [15:0] hist_old;
		logic signed [15:0] hist_new;
		int                 frame_pos;
		int                 shift_amt;
		logic [3:0]         pred_sel;
		pcm_word_t          expected_pcm [$];
		int                 errors;
		int                 samples_checked;
		int                 frames_closed;
		int                 clipped;

		function new();
			foreach (coef_mem[i])
				coef_mem[i] = '0;
			hist_old = '0;
			hist_new = '0;
			frame_pos = 0;
			shift_amt = 0;
			pred_sel = '0;
			errors = 0;
			samples_checked = 0;
			frames_closed = 0;
			clipped = 0;
		endfunction

		// Effective tap weight: stored value shifted down by two, then doubled
		function longint tap_weight(int tap);
			if (int'(pred_sel) >= NUM_PRED)
				return 0;
			return (longint'(coef_mem[int'(pred_sel) * 2 + tap]) >>> 2) * 2;
		endfunction

		// Decode one nibble and advance the history
		function logic signed [15:0] next_sample(logic [3:0] nib);
			longint acc;
			acc = longint'($signed(nib)) * (longint'(1) << shift_amt);
			acc += longint'(hist_old) * tap_weight(0) + longint'(hist_new) * tap_weight(1);
			acc = acc >>> OUT_SHIFT;
			if (acc > longint'(SAT_MAX)) begin
				acc = longint'(SAT_MAX);
				clipped++;
			end else if (acc < longint'(SAT_MIN)) begin
				acc = longint'(SAT_MIN);
				clipped++;
			end
			hist_old = hist_new;
			hist_new = acc[15:0];
			return acc[15:0];
		endfunction

		// Apply one accepted input word to the model
		function void note_input(req_t req, logic [4:0] slot, logic [15:0] val,
				logic [7:0] fb);
			pcm_word_t w;
			logic      last;
			case (req)
				REQ_COEF: begin
					if (int'(slot) < NUM_PRED * 2)
						coef_mem[slot] = val;
				end
				REQ_HIST: begin
					if (slot == 5'd0)
						hist_old = val;
					else if (slot == 5'd1)
						hist_new = val;
				end
				REQ_CLEAR: begin
					hist_old = '0;
					hist_new = '0;
					frame_pos = 0;
				end
				default: begin
					if (frame_pos == 0) begin
						// header: latch shift and predictor
						shift_amt = int'(fb[7:4]) + SHIFT_BASE;
						pred_sel = fb[3:0];
						frame_pos = 1;
					end else begin
						last = (frame_pos >= FRAME_BYTES - 1);
						w.sample = next_sample(fb[7:4]);
						w.pair_last = 1'b0;
						w.frame_end = 1'b0;
						expected_pcm.push_back(w);
						w.sample = next_sample(fb[3:0]);
						w.pair_last = 1'b1;
						w.frame_end = last;
						expected_pcm.push_back(w);
						frame_pos = last ? 0 : frame_pos + 1;
					end
				end
			endcase
		endfunction

		// Compare one output word against the oldest expected sample
		function void check_result(logic [15:0] data, logic pl, logic fe);
			pcm_word_t want;
			if (expected_pcm.size() == 0) begin
				$display("%0t: unexpected sample %0d (pair_last %b frame_end %b)",
					$time, $signed(data), pl, fe);
				errors++;
				return;
			end
			want = expected_pcm.pop_front();
			samples_checked++;
			if (want.frame_end)
				frames_closed++;
			if (data !== want.sample) begin
				$display("%0t: sample expected %0d, actual %0d",
					$time, want.sample, $signed(data));
				errors++;
			end
			if (pl !== want.pair_last) begin
				$display("%0t: pair_last expected %b, actual %b", $time, want.pair_last, pl);
				errors++;
			end
			if (fe !== want.frame_end) begin
				$display("%0t: frame_end expected %b, actual %b", $time, want.frame_end, fe);
				errors++;
			end
		endfunction

		function int pending();
			return expected_pcm.size();
		endfunction

		function void report_leftover();
			if (expected_pcm.size() != 0) begin
				$display("%0t: %0d expected samples never came out", $time, expected_pcm.size());
				errors += expected_pcm.size();
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;   // slot_index[4:0], write_value[20:5], frame_byte[28:21], zero
	logic [IN_TUSER_W-1:0]  s_tuser = '0;   // req_type[1:0]
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // sample[15:0]
	logic                   m_tuser;        // pair_last[0]
	logic                   m_tlast;

	pcm_scoreboard board;
	int            burst_left = 0;
	int            words_sent = 0;
	logic          soak_on = 1'b0;
	logic          long_hold_done = 1'b0;

	adpcm_frame_decoder_core #(
		.NUM_PREDICTORS(NUM_PRED)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always #5 clk = ~clk;

	// Offer one word in bursts with random gaps; hold until it is taken
	task automatic send_item(req_t req, logic [4:0] slot, logic [15:0] val, logic [7:0] fb);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {3'b000, fb, val, slot};
		do @(posedge clk); while (!s_tready);
		board.note_input(req, slot, val, fb);
		burst_left--;
		if (!(req == REQ_HIST && slot > 5'd1))
			words_sent++;
	endtask

	// Stop sending until every owed sample has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	function automatic logic [15:0] random_coef();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2, 3: return 16'($urandom_range(0, 4095) - 2048);
			default: return 16'($urandom);
		endcase
	endfunction

	// One frame: optional setup writes, header, up to eight data bytes
	task automatic run_frame();
		int p;
		int sl;
		p = $urandom_range(0, NUM_PRED - 1);
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				sl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : p * 2 + $urandom_range(0, 1);
				send_item(REQ_COEF, 5'(sl), random_coef(), 8'($urandom));
			end
		end
		if ($urandom_range(0, 7) == 0)
			send_item(REQ_HIST, 5'($urandom_range(0, 3)), random_coef(), 8'($urandom));
		if (board.frame_pos != 0 || $urandom_range(0, 9) == 0)
			send_item(REQ_CLEAR, 5'($urandom), 16'($urandom), 8'($urandom));
		send_item(REQ_BYTE, 5'($urandom), 16'($urandom), {4'($urandom), 4'(p)});
		for (int i = 0; i < 8; i++) begin
			// coefficient change in the middle of a frame
			if ($urandom_range(0, 19) == 0)
				send_item(REQ_COEF, 5'(p * 2 + $urandom_range(0, 1)), random_coef(), 8'($urandom));
			// broken frame: restart before the last byte
			if ($urandom_range(0, 59) == 0) begin
				send_item(REQ_CLEAR, 5'($urandom), 16'($urandom), 8'($urandom));
				return;
			end
			send_item(REQ_BYTE, 5'($urandom), 16'($urandom), 8'($urandom));
		end
	endtask

	// Check every word the receiver takes
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata, m_tuser, m_tlast);
	end

	// Receiver: stretches of free flow, random and slow stalls, and holds
	initial begin
		rx_mode_t mode;
		int       span;
		wait (arst_n === 1'b1);
		forever begin
			if (soak_on && !long_hold_done) begin
				mode = RX_HOLD;
				span = 400;
				long_hold_done = 1'b1;
			end else begin
				mode = rx_mode_t'($urandom_range(0, 2));
				if ($urandom_range(0, 15) == 0)
					mode = RX_HOLD;
				span = (mode == RX_HOLD) ? $urandom_range(20, 80) : $urandom_range(10, 150);
			end
			repeat (span) begin
				@(posedge clk);
				case (mode)
					RX_FREE: m_tready <= 1'b1;
					RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
					RX_SLOW: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= 1'b0;
				endcase
			end
		end
	end

	// Abort a hung run
	initial begin
		#5_000_000;
		$display("adpcm_frame_decoder_core: mismatch");
		$finish;
	end

	// Main sequence
	initial begin
		int directed_words;
		int frames;
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// extreme coefficients and history, ignored history slot
		send_item(REQ_COEF, 5'd0, 16'h7FFF, 8'h00);
		send_item(REQ_COEF, 5'd1, 16'h8000, 8'h00);
		send_item(REQ_HIST, 5'd0, 16'h7FFF, 8'h00);
		send_item(REQ_HIST, 5'd1, 16'h8000, 8'h00);
		send_item(REQ_HIST, 5'd31, 16'h5555, 8'h00);
		// largest shift, then restart in the middle of the frame
		send_item(REQ_BYTE, 5'd0, 16'h0000, 8'hF0);
		send_item(REQ_BYTE, 5'd0, 16'h0000, 8'h7F);
		send_item(REQ_BYTE, 5'd0, 16'h0000, 8'h88);
		send_item(REQ_CLEAR, 5'd0, 16'h0000, 8'h00);
		// smallest shift, coefficient write mid-frame, full frame to its end
		send_item(REQ_BYTE, 5'd0, 16'h0000, 8'h00);
		send_item(REQ_BYTE, 5'd0, 16'h0000, 8'h80);
		send_item(REQ_COEF, 5'd0, 16'h0000, 8'h00);
		send_item(REQ_BYTE, 5'd0, 16'h0000, 8'h08);
		send_item(REQ_BYTE, 5'd0, 16'h0000, 8'hFF);
		send_item(REQ_BYTE, 5'd0, 16'h0000, 8'h01);
		send_item(REQ_BYTE, 5'd0, 16'h0000, 8'h10);
		send_item(REQ_BYTE, 5'd0, 16'h0000, 8'h7F);
		send_item(REQ_BYTE, 5'd0, 16'h0000, 8'h80);
		send_item(REQ_BYTE, 5'd0, 16'h0000, 8'hA5);
		// highest predictor
		send_item(REQ_COEF, 5'd31, 16'hFFFF, 8'h00);
		send_item(REQ_COEF, 5'd30, 16'h4000, 8'h00);
		send_item(REQ_BYTE, 5'd0, 16'h0000, 8'h9F);
		send_item(REQ_BYTE, 5'd0, 16'h0000, 8'h77);
		send_item(REQ_CLEAR, 5'd0, 16'h0000, 8'h00);
		wait_drained();

		directed_words = words_sent;
		frames = 0;
		soak_on = 1'b1;
		while (words_sent - directed_words < SOAK_WORDS) begin
			// noise: fully random words
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4))
					send_item(req_t'($urandom_range(0, 3)), 5'($urandom), 16'($urandom),
						8'($urandom));
			end
			run_frame();
			frames++;
			if (frames == 90)
				wait_drained();
		end

		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		board.report_leftover();

		$display("covered %0d input words: %0d samples checked, %0d frame ends, %0d clipped",
			words_sent, board.samples_checked, board.frames_closed, board.clipped);
		if (board.errors == 0)
			$display("adpcm_frame_decoder_core: match");
		else
			$display("adpcm_frame_decoder_core: mismatch");
		$finish;
	end

endmodule
